// ===== sv/least_squares_line_fit_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the line fit block
// Clocked implication forms shared by the checker.
// ----------------------------------------------------------------------------
`ifndef LEAST_SQUARES_LINE_FIT_MACROS_SVH
`define LEAST_SQUARES_LINE_FIT_MACROS_SVH

// same-cycle implication
`define LSQ_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LSQ_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/lsq_pkg.sv =====
// ----------------------------------------------------------------------------
// lsq_pkg
// Widths, operation codes and control structs of the line fit block.
// ----------------------------------------------------------------------------
package lsq_pkg;

  localparam int MAX_PAIRS_DEF = 1024;

  localparam int XW   = 24;   // sample width
  localparam int SXW  = 40;   // sum x / sum y
  localparam int SW   = 64;   // wide sums, multiplier operands
  localparam int WW   = 128;  // products, differences, quotients
  localparam int RW   = 32;   // slope / intercept
  localparam int CRW  = 18;   // correlation
  localparam int PCW  = 11;   // pair count field
  localparam int OPW  = 4;

  localparam int S_DW = 48;
  localparam int M_DW = 96;
  localparam int M_UW = 3;

  localparam logic signed [RW-1:0] ONE_Q16 = 32'sh0001_0000;
  localparam logic [RW-1:0] LIM_NEG_Q16 = 32'h8000_0000;
  localparam logic [RW-1:0] LIM_POS_Q16 = 32'h7FFF_FFFF;
  localparam logic [RW-1:0] LIM_CORR    = 32'h0001_0000;

  // fit sequence, in execution order
  localparam logic [OPW-1:0] OP_N_SXY  = 4'd0;
  localparam logic [OPW-1:0] OP_SX_SY  = 4'd1;
  localparam logic [OPW-1:0] OP_N_SXX  = 4'd2;
  localparam logic [OPW-1:0] OP_SX_SX  = 4'd3;
  localparam logic [OPW-1:0] OP_SXX_SY = 4'd4;
  localparam logic [OPW-1:0] OP_SX_SXY = 4'd5;
  localparam logic [OPW-1:0] OP_DIV_K  = 4'd6;
  localparam logic [OPW-1:0] OP_DIV_B  = 4'd7;
  localparam logic [OPW-1:0] OP_SCAN   = 4'd8;
  localparam logic [OPW-1:0] OP_N_SYY  = 4'd9;
  localparam logic [OPW-1:0] OP_SY_SY  = 4'd10;
  localparam logic [OPW-1:0] OP_SQRT_X = 4'd11;
  localparam logic [OPW-1:0] OP_SQRT_Y = 4'd12;
  localparam logic [OPW-1:0] OP_ROOTS  = 4'd13;
  localparam logic [OPW-1:0] OP_DIV_R  = 4'd14;

  typedef struct packed {
    logic           load;
    logic           mul_start;
    logic           div_start;
    logic           scan_start;
    logic           sqrt_start;
    logic           wb;
    logic           out_load;
    logic [OPW-1:0] op;
  } cmd_t;

  typedef struct packed {
    logic mul_done;
    logic div_done;
    logic scan_done;
    logic sqrt_done;
  } stat_t;

endpackage

// ===== sv/lsq_mul.sv =====
// ----------------------------------------------------------------------------
// lsq_mul
// 64x64 -> 128 multiplier, one 32x32 partial product per cycle.
// ----------------------------------------------------------------------------
module lsq_mul (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic                    sgn,
  input  logic [lsq_pkg::SW-1:0]  a,
  input  logic [lsq_pkg::SW-1:0]  b,
  output logic                    done,
  output logic [lsq_pkg::WW-1:0]  p
);
  import lsq_pkg::*;

  logic [SW-1:0] ma, mb;
  logic          neg;
  logic          busy;
  logic [2:0]    cnt;
  logic [31:0]   op_a, op_b;
  logic [63:0]   pp;
  logic [1:0]    pp_sh;
  logic          pp_v;
  logic [WW-1:0] acc;

  assign op_a = cnt[1] ? ma[63:32] : ma[31:0];
  assign op_b = cnt[0] ? mb[63:32] : mb[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      pp_v <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        pp_v <= 1'b0;
      end else if (busy) begin
        pp_v <= (cnt <= 3'd3);
        cnt  <= cnt + 3'd1;
        if (cnt == 3'd5) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      ma  <= (sgn && a[SW-1]) ? (~a + 64'd1) : a;
      mb  <= (sgn && b[SW-1]) ? (~b + 64'd1) : b;
      neg <= sgn && (a[SW-1] ^ b[SW-1]);
      acc <= '0;
    end else if (busy) begin
      pp    <= op_a * op_b;
      pp_sh <= {1'b0, cnt[1]} + {1'b0, cnt[0]};
      if (pp_v)
        acc <= acc + ({64'd0, pp} << {pp_sh, 5'd0});
      if (cnt == 3'd5)
        p <= neg ? (~acc + 128'd1) : acc;
    end
  end

endmodule

// ===== sv/lsq_div.sv =====
// ----------------------------------------------------------------------------
// lsq_div
// Restoring divider, one quotient bit per cycle, rounds half away from
// zero and clamps to a signed limit.
// ----------------------------------------------------------------------------
module lsq_div (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [lsq_pkg::WW-1:0] num,
  input  logic [lsq_pkg::WW-1:0] den,
  input  logic [lsq_pkg::RW-1:0] neg_lim,
  input  logic [lsq_pkg::RW-1:0] pos_lim,
  output logic                   done,
  output logic [lsq_pkg::RW-1:0] res
);
  import lsq_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_ROUND = 2'd2;
  localparam logic [1:0] ST_FIN   = 2'd3;

  logic [1:0]    state;
  logic [6:0]    cnt;
  logic [WW-1:0] qn, rem, d, rs;
  logic          neg;
  logic [RW-1:0] lim, qc;
  logic          big;

  assign rs  = {rem[WW-2:0], qn[WW-1]};
  assign big = (qn[WW-1:RW] != '0) || (qn[RW-1:0] > lim);
  assign qc  = big ? lim : qn[RW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
      cnt   <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (start) begin
            state <= ST_RUN;
            cnt   <= '0;
          end
        end
        ST_RUN: begin
          cnt <= cnt + 7'd1;
          if (cnt == 7'd127)
            state <= ST_ROUND;
        end
        ST_ROUND: state <= ST_FIN;
        ST_FIN: begin
          state <= ST_IDLE;
          done  <= 1'b1;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (start) begin
          neg <= num[WW-1];
          qn  <= num[WW-1] ? (~num + 128'd1) : num;
          rem <= '0;
          d   <= den;
          lim <= num[WW-1] ? neg_lim : pos_lim;
        end
      end
      ST_RUN: begin
        if (rs >= d) begin
          rem <= rs - d;
          qn  <= {qn[WW-2:0], 1'b1};
        end else begin
          rem <= rs;
          qn  <= {qn[WW-2:0], 1'b0};
        end
      end
      ST_ROUND: begin
        if ({rem[WW-2:0], 1'b0} >= d)
          qn <= qn + 128'd1;
      end
      ST_FIN: res <= neg ? (~qc + 32'd1) : qc;
      default: ;
    endcase
  end

endmodule

// ===== sv/lsq_datapath.sv =====
// ----------------------------------------------------------------------------
// lsq_datapath
// Sample store, running sums, fit registers, square root and result
// registers; multiply and divide run in their own units.
// ----------------------------------------------------------------------------
module lsq_datapath #(
  parameter int MAX_PAIRS = lsq_pkg::MAX_PAIRS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  lsq_pkg::cmd_t                  cmd,
  output lsq_pkg::stat_t                 stat,
  input  logic signed [lsq_pkg::XW-1:0]  x_value,
  input  logic signed [lsq_pkg::XW-1:0]  y_value,
  output logic signed [lsq_pkg::RW-1:0]  slope,
  output logic signed [lsq_pkg::RW-1:0]  intercept,
  output logic signed [lsq_pkg::CRW-1:0] correlation,
  output logic                           fit_degenerate,
  output logic                           correlation_undefined,
  output logic                           overflowed,
  output logic [lsq_pkg::PCW-1:0]        pair_count
);
  import lsq_pkg::*;

  localparam int AW = $clog2(MAX_PAIRS);
  localparam int CW = $clog2(MAX_PAIRS + 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(MAX_PAIRS);

  // load path
  logic [CW-1:0]           count;
  logic                    full;
  logic                    ovf;
  logic                    ld_v;
  logic signed [XW-1:0]    ld_x, ld_y;
  logic signed [2*XW-1:0]  ld_xx, ld_xy;
  logic signed [SXW-1:0]   sum_x, sum_y;
  logic [SW-1:0]           sum_xx, sum_xy;
  logic [XW-1:0]           y_mem [MAX_PAIRS];

  // fit registers
  logic [WW-1:0] term, nxy, dx, nb, dy, den_r;
  logic [RW-1:0] k_r, b_r, r_r;
  logic [SW-1:0] rx, ry, syy;

  // scan
  logic                   sc_act, sc_busy, rd_v, sq_pv;
  logic [CW-1:0]          sc_addr;
  logic signed [XW-1:0]   rd_y;
  logic signed [2*XW-1:0] sc_sq;

  // square root
  logic           sq_busy, sq_done;
  logic [5:0]     sq_cnt;
  logic [WW-1:0]  sq_src;
  logic [65:0]    sq_rem;
  logic [SW-1:0]  sq_root;
  logic [67:0]    sq_rs, sq_tr;

  // unit hookup
  logic [SW-1:0] mul_a, mul_b;
  logic          mul_sgn, mul_done;
  logic [WW-1:0] mul_p;
  logic [WW-1:0] div_num, div_den;
  logic [RW-1:0] div_nlim, div_plim, div_res;
  logic          div_done;

  logic [SW-1:0] n64, sx64, sy64;
  logic          degen, dy_bad, undef;

  assign full = (count == FULL_COUNT);
  assign n64  = SW'(count);
  assign sx64 = {{(SW-SXW){sum_x[SXW-1]}}, sum_x};
  assign sy64 = {{(SW-SXW){sum_y[SXW-1]}}, sum_y};

  // ---- load: square/product stage, then accumulate
  always_ff @(posedge clk) begin
    if (rst) begin
      ld_v <= 1'b0;
    end else begin
      ld_v <= cmd.load && !full;
    end
  end

  always_ff @(posedge clk) begin
    ld_x  <= x_value;
    ld_y  <= y_value;
    ld_xx <= x_value * x_value;
    ld_xy <= x_value * y_value;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      ovf    <= 1'b0;
      sum_x  <= '0;
      sum_y  <= '0;
      sum_xx <= '0;
      sum_xy <= '0;
    end else if (cmd.out_load) begin
      count  <= '0;
      ovf    <= 1'b0;
      sum_x  <= '0;
      sum_y  <= '0;
      sum_xx <= '0;
      sum_xy <= '0;
    end else begin
      if (cmd.load) begin
        if (full) ovf <= 1'b1;
        else      count <= count + 1'b1;
      end
      if (ld_v) begin
        sum_x  <= sum_x + {{(SXW-XW){ld_x[XW-1]}}, ld_x};
        sum_y  <= sum_y + {{(SXW-XW){ld_y[XW-1]}}, ld_y};
        sum_xx <= sum_xx + {{(SW-2*XW){ld_xx[2*XW-1]}}, ld_xx};
        sum_xy <= sum_xy + {{(SW-2*XW){ld_xy[2*XW-1]}}, ld_xy};
      end
    end
  end

  // ---- y store: write on load, registered read during the scan
  always_ff @(posedge clk) begin
    if (cmd.load && !full)
      y_mem[count[AW-1:0]] <= y_value;
    if (sc_busy && (sc_addr < count))
      rd_y <= y_mem[sc_addr[AW-1:0]];
  end

  // ---- scan: sum of y squared over the stored pairs
  always_ff @(posedge clk) begin
    if (rst) begin
      sc_act  <= 1'b0;
      sc_busy <= 1'b0;
      rd_v    <= 1'b0;
      sq_pv   <= 1'b0;
    end else begin
      sq_pv <= rd_v;
      if (cmd.scan_start) begin
        sc_act  <= 1'b1;
        sc_busy <= 1'b1;
        rd_v    <= 1'b0;
      end else begin
        if (sc_busy) begin
          rd_v <= (sc_addr < count);
          if (sc_addr >= count) sc_busy <= 1'b0;
        end else begin
          rd_v <= 1'b0;
        end
        if (stat.scan_done) sc_act <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    sc_sq <= rd_y * rd_y;
    if (cmd.scan_start) begin
      sc_addr <= '0;
      syy     <= '0;
    end else begin
      if (sc_busy && (sc_addr < count)) sc_addr <= sc_addr + 1'b1;
      if (sq_pv) syy <= syy + {{(SW-2*XW){sc_sq[2*XW-1]}}, sc_sq};
    end
  end

  // ---- square root, two radicand bits per cycle
  assign sq_rs = {sq_rem, sq_src[WW-1:WW-2]};
  assign sq_tr = {2'b00, sq_root, 2'b01};

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_busy <= 1'b0;
      sq_done <= 1'b0;
      sq_cnt  <= '0;
    end else begin
      sq_done <= 1'b0;
      if (cmd.sqrt_start) begin
        sq_busy <= 1'b1;
        sq_cnt  <= '0;
      end else if (sq_busy) begin
        sq_cnt <= sq_cnt + 6'd1;
        if (sq_cnt == 6'd63) begin
          sq_busy <= 1'b0;
          sq_done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sqrt_start) begin
      sq_src  <= (cmd.op == OP_SQRT_X) ? {dx[WW-33:0], 32'd0} : {dy[WW-33:0], 32'd0};
      sq_rem  <= '0;
      sq_root <= '0;
    end else if (sq_busy) begin
      sq_src <= {sq_src[WW-3:0], 2'b00};
      if (sq_rs >= sq_tr) begin
        sq_rem  <= 66'(sq_rs - sq_tr);
        sq_root <= {sq_root[SW-2:0], 1'b1};
      end else begin
        sq_rem  <= sq_rs[65:0];
        sq_root <= {sq_root[SW-2:0], 1'b0};
      end
    end
  end

  // ---- operand selection
  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    mul_sgn = 1'b1;
    case (cmd.op)
      OP_N_SXY:  begin mul_a = n64;    mul_b = sum_xy; end
      OP_SX_SY:  begin mul_a = sx64;   mul_b = sy64;   end
      OP_N_SXX:  begin mul_a = n64;    mul_b = sum_xx; end
      OP_SX_SX:  begin mul_a = sx64;   mul_b = sx64;   end
      OP_SXX_SY: begin mul_a = sum_xx; mul_b = sy64;   end
      OP_SX_SXY: begin mul_a = sx64;   mul_b = sum_xy; end
      OP_N_SYY:  begin mul_a = n64;    mul_b = syy;    end
      OP_SY_SY:  begin mul_a = sy64;   mul_b = sy64;   end
      OP_ROOTS:  begin mul_a = rx;     mul_b = ry;     mul_sgn = 1'b0; end
      default: ;
    endcase
  end

  always_comb begin
    div_num  = {nxy[WW-17:0], 16'd0};
    div_den  = dx;
    div_nlim = LIM_NEG_Q16;
    div_plim = LIM_POS_Q16;
    case (cmd.op)
      OP_DIV_B: div_num = nb;
      OP_DIV_R: begin
        div_num  = {nxy[WW-49:0], 48'd0};
        div_den  = den_r;
        div_nlim = LIM_CORR;
        div_plim = LIM_CORR;
      end
      default: ;
    endcase
  end

  lsq_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.mul_start),
    .sgn   (mul_sgn),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .p     (mul_p)
  );

  lsq_div u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (cmd.div_start),
    .num     (div_num),
    .den     (div_den),
    .neg_lim (div_nlim),
    .pos_lim (div_plim),
    .done    (div_done),
    .res     (div_res)
  );

  // ---- writeback of unit results
  always_ff @(posedge clk) begin
    if (cmd.wb) begin
      case (cmd.op)
        OP_N_SXY, OP_N_SXX, OP_SXX_SY, OP_N_SYY: term <= mul_p;
        OP_SX_SY:  nxy   <= term - mul_p;
        OP_SX_SX:  dx    <= term - mul_p;
        OP_SX_SXY: nb    <= term - mul_p;
        OP_SY_SY:  dy    <= term - mul_p;
        OP_ROOTS:  den_r <= mul_p;
        OP_DIV_K:  k_r   <= div_res;
        OP_DIV_B:  b_r   <= div_res;
        OP_DIV_R:  r_r   <= div_res;
        OP_SQRT_X: rx    <= sq_root;
        OP_SQRT_Y: ry    <= sq_root;
        default: ;
      endcase
    end
  end

  // nonpositive denominators flag the special cases
  assign degen  = dx[WW-1] || (dx == '0);
  assign dy_bad = dy[WW-1] || (dy == '0);
  assign undef  = degen || dy_bad || (rx == '0) || (ry == '0);

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      slope                 <= degen ? ONE_Q16 : k_r;
      intercept             <= degen ? '0 : b_r;
      correlation           <= undef ? '0 : r_r[CRW-1:0];
      fit_degenerate        <= degen;
      correlation_undefined <= undef;
      overflowed            <= ovf;
      pair_count            <= PCW'(count);
    end
  end

  assign stat.mul_done  = mul_done;
  assign stat.div_done  = div_done;
  assign stat.scan_done = sc_act && !sc_busy && !rd_v && !sq_pv;
  assign stat.sqrt_done = sq_done;

endmodule

// ===== sv/lsq_ctrl.sv =====
// ----------------------------------------------------------------------------
// lsq_ctrl
// Sequencer: load phase, fit operation sequence, result hand-off.
// ----------------------------------------------------------------------------
module lsq_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_tvalid,
  input  logic           s_tlast,
  output logic           s_tready,
  output logic           m_tvalid,
  input  logic           m_tready,
  output lsq_pkg::cmd_t  cmd,
  input  lsq_pkg::stat_t stat
);
  import lsq_pkg::*;

  localparam logic [2:0] ST_LOAD  = 3'd0;
  localparam logic [2:0] ST_DRAIN = 3'd1;
  localparam logic [2:0] ST_ISSUE = 3'd2;
  localparam logic [2:0] ST_WAIT  = 3'd3;
  localparam logic [2:0] ST_WRITE = 3'd4;

  localparam logic [1:0] K_MUL  = 2'd0;
  localparam logic [1:0] K_DIV  = 2'd1;
  localparam logic [1:0] K_SCAN = 2'd2;
  localparam logic [1:0] K_SQRT = 2'd3;

  logic [2:0]     state;
  logic [OPW-1:0] step;
  logic [1:0]     kind;
  logic           unit_done;
  logic           accept;

  function automatic logic [1:0] op_kind(input logic [OPW-1:0] op);
    case (op)
      OP_DIV_K, OP_DIV_B, OP_DIV_R: op_kind = K_DIV;
      OP_SCAN:                      op_kind = K_SCAN;
      OP_SQRT_X, OP_SQRT_Y:         op_kind = K_SQRT;
      default:                      op_kind = K_MUL;
    endcase
  endfunction

  assign kind     = op_kind(step);
  assign s_tready = (state == ST_LOAD);
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    case (kind)
      K_DIV:   unit_done = stat.div_done;
      K_SCAN:  unit_done = stat.scan_done;
      K_SQRT:  unit_done = stat.sqrt_done;
      default: unit_done = stat.mul_done;
    endcase
  end

  assign cmd.load       = accept;
  assign cmd.mul_start  = (state == ST_ISSUE) && (kind == K_MUL);
  assign cmd.div_start  = (state == ST_ISSUE) && (kind == K_DIV);
  assign cmd.scan_start = (state == ST_ISSUE) && (kind == K_SCAN);
  assign cmd.sqrt_start = (state == ST_ISSUE) && (kind == K_SQRT);
  assign cmd.wb         = (state == ST_WAIT) && unit_done;
  assign cmd.out_load   = (state == ST_WRITE) && (!m_tvalid || m_tready);
  assign cmd.op         = step;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_LOAD;
      step     <= OP_N_SXY;
      m_tvalid <= 1'b0;
    end else begin
      if (cmd.out_load)  m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;

      case (state)
        ST_LOAD: begin
          if (accept && s_tlast) state <= ST_DRAIN;
        end
        ST_DRAIN: begin
          step  <= OP_N_SXY;
          state <= ST_ISSUE;
        end
        ST_ISSUE: state <= ST_WAIT;
        ST_WAIT: begin
          if (unit_done) begin
            if (step == OP_DIV_R) begin
              state <= ST_WRITE;
            end else begin
              step  <= step + 4'd1;
              state <= ST_ISSUE;
            end
          end
        end
        ST_WRITE: begin
          if (cmd.out_load) state <= ST_LOAD;
        end
        default: state <= ST_LOAD;
      endcase
    end
  end

endmodule

// ===== sv/least_squares_line_fit.sv =====
// ----------------------------------------------------------------------------
// least_squares_line_fit
// Least-squares line fit with Pearson correlation over a set of sample pairs.
// ----------------------------------------------------------------------------
//
//  channel  | dir | carries
//  ---------+-----+-----------------------------------------------------------
//  s_*      | in  | one (x, y) pair per item, tlast closes the set
//  m_*      | out | one fit result per set: slope, intercept, r, flags, count
//
//  Loading takes one pair per cycle. After the closing pair the block stops
//  taking input until the fit result is loaded for output (n = stored pairs):
//  three 128-bit quotients at one bit per cycle, the walk of the y store over
//  the n pairs, two 64-step square roots and nine multi-cycle products.
//  Reset is synchronous and clears counts, sums and handshake state; the
//  store holds no reset value. A waiting result does not block loading of
//  the next set; only the next fit waits for the output slot to free up.
//
module least_squares_line_fit #(
  parameter int MAX_PAIRS = lsq_pkg::MAX_PAIRS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  // [23:0] x_value, [47:24] y_value
  input  logic [lsq_pkg::S_DW-1:0]  s_tdata,
  input  logic                      s_tlast,   // last_sample
  output logic                      m_tvalid,
  input  logic                      m_tready,
  // [31:0] slope, [63:32] intercept, [81:64] correlation,
  // [92:82] pair_count, [95:93] zero
  output logic [lsq_pkg::M_DW-1:0]  m_tdata,
  // [0] fit_degenerate, [1] correlation_undefined, [2] overflowed
  output logic [lsq_pkg::M_UW-1:0]  m_tuser
);
  import lsq_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  logic signed [RW-1:0]  slope, intercept;
  logic signed [CRW-1:0] correlation;
  logic                  fit_degenerate, correlation_undefined, overflowed;
  logic [PCW-1:0]        pair_count;

  lsq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tlast  (s_tlast),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd),
    .stat     (stat)
  );

  lsq_datapath #(
    .MAX_PAIRS (MAX_PAIRS)
  ) u_dp (
    .clk                   (clk),
    .rst                   (rst),
    .cmd                   (cmd),
    .stat                  (stat),
    .x_value               (s_tdata[XW-1:0]),
    .y_value               (s_tdata[2*XW-1:XW]),
    .slope                 (slope),
    .intercept             (intercept),
    .correlation           (correlation),
    .fit_degenerate        (fit_degenerate),
    .correlation_undefined (correlation_undefined),
    .overflowed            (overflowed),
    .pair_count            (pair_count)
  );

  // result fields packed from the low end, zero fill to whole bytes
  assign m_tdata = {3'b000, pair_count, correlation, intercept, slope};
  assign m_tuser = {overflowed, correlation_undefined, fit_degenerate};

endmodule

// ===== sv/lsq_checker.sv =====
// ----------------------------------------------------------------------------
// lsq_checker
// Port-level checks of the line fit block, bound to the top level.
// ----------------------------------------------------------------------------
`include "least_squares_line_fit_macros.svh"

module lsq_checker (
  input logic                     clk,
  input logic                     rst,
  input logic                     s_tvalid,
  input logic                     s_tready,
  input logic [lsq_pkg::S_DW-1:0] s_tdata,
  input logic                     s_tlast,
  input logic                     m_tvalid,
  input logic                     m_tready,
  input logic [lsq_pkg::M_DW-1:0] m_tdata,
  input logic [lsq_pkg::M_UW-1:0] m_tuser
);
  import lsq_pkg::*;

  logic closing;
  assign closing = s_tvalid && s_tready && s_tlast && (s_tdata != '1 || s_tdata == '1);

  `LSQ_ASSERT_NXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")
  `LSQ_ASSERT_NXT(a_fit_busy, closing, !s_tready, "input taken right after closing pair")
  `LSQ_ASSERT_IMP(a_corr_range, m_tvalid, ($signed(m_tdata[81:64]) <= 18'sd65536) && ($signed(m_tdata[81:64]) >= -18'sd65536), "correlation beyond unity")
  `LSQ_ASSERT_IMP(a_degen, m_tvalid && m_tuser[0], (m_tdata[31:0] == ONE_Q16) && (m_tdata[63:32] == '0), "degenerate fit not forced to unit slope")
  `LSQ_ASSERT_IMP(a_undef, m_tvalid && m_tuser[1], m_tdata[81:64] == '0, "undefined correlation not zero")

endmodule

bind least_squares_line_fit lsq_checker u_chk (.*);
